// ===== src/sksi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted key set insert block.
// No dependencies; every other file refers to this package by scoped names.
package sksi_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] ST_NEW_ENTRY = 3'd0;
   localparam logic [2:0] ST_MERGED    = 3'd1;
   localparam logic [2:0] ST_ID_HELD   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_CLEARED   = 3'd4;
   localparam logic [2:0] ST_READ_OK   = 3'd5;
   localparam logic [2:0] ST_BAD_RANK  = 3'd6;

   typedef struct packed {
      logic [1:0]         op;
      logic [4:0]         item_id;
      logic signed [31:0] key_value;
      logic [3:0]         rank;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         position;
      logic [4:0]         entry_count;
      logic signed [31:0] entry_key;
      logic [31:0]        entry_members;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic apply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_result;
   } stat_type;

endpackage

// ===== src/sorted_key_set_insert_top.sv =====
`timescale 1ns / 1ps
// Top level of the sorted key set: controller plus entry datapath.
// Depends on sksi_pkg, sksi_ctrl and sksi_datapath.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      taken when start high and busy low
//   result    rsp_strobe, rsp_item       one cycle, taken at its closing edge
//
// Each beat passes capture, a compare against all held keys in
// parallel, then an update of the table and the result register; the strobe shows
// in the cycle after the update, while a new beat may already be taken.
// Reset empties the table; key and mask storage is not cleared.
// The receiver cannot stall; the unused op code yields no result.
module sorted_key_set_insert_top #(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_ITEMS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sksi_pkg::req_type req_item,
   output logic              rsp_strobe,
   output sksi_pkg::rsp_type rsp_item
);

   sksi_pkg::cmd_type  cmd;
   sksi_pkg::stat_type stat;

   sksi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   sksi_datapath #(
      .ENTRIES (MAX_ENTRIES),
      .ITEMS   (MAX_ITEMS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

// ===== src/sksi_datapath.sv =====
`timescale 1ns / 1ps
// Entry table, key compare row and result register of the sorted key set.
// Depends on sksi_pkg; driven by sksi_ctrl through cmd_type / stat_type.
module sksi_datapath #(
   parameter int ENTRIES = 16,
   parameter int ITEMS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  sksi_pkg::cmd_type cmd,
   output sksi_pkg::stat_type stat,
   input  sksi_pkg::req_type req_item,
   output sksi_pkg::rsp_type rsp_item
);

   localparam int IDX_W  = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int MASK_W = (ITEMS < 32) ? ITEMS : 32;
   localparam int PW     = (IDX_W > 4) ? IDX_W : 4;
   localparam int CW     = (CNT_W > 5) ? CNT_W : 5;

   sksi_pkg::req_type  req_ff;
   sksi_pkg::rsp_type  rsp_ff, rsp_in;
   logic signed [31:0] key_ff  [ENTRIES];
   logic [MASK_W-1:0]  mask_ff [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ENTRIES-1:0] lt_ff, eq_ff, hit_ff;
   logic [ENTRIES-1:0] lt_in, eq_in, hit_in;

   logic [MASK_W-1:0]  id_bit;
   logic               id_bad;
   logic [ENTRIES-1:0] pos_oh;
   logic [IDX_W-1:0]   pos;
   logic [PW-1:0]      pos_wide;
   logic [PW-1:0]      rank_wide;
   logic [IDX_W-1:0]   rank_idx;
   logic [CW-1:0]      count_wide;
   logic signed [31:0] sel_key;
   logic [MASK_W-1:0]  sel_mask;
   logic               merged, any_hit, full, do_insert, do_merge;

   assign id_bit = {{(MASK_W-1){1'b0}}, 1'b1} << req_ff.item_id;
   assign id_bad = int'(req_ff.item_id) >= ITEMS;

   // compare row: one cell per entry, qualified by fill count
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         lt_in[i]  = (i < int'(count_ff)) && (key_ff[i] < req_ff.key_value);
         eq_in[i]  = (i < int'(count_ff)) && (key_ff[i] == req_ff.key_value);
         hit_in[i] = (i < int'(count_ff)) && (|(mask_ff[i] & id_bit));
      end
   end

   // lt is a prefix of valid entries, so the insert point is its edge
   always_comb begin
      pos_oh[0] = !lt_ff[0];
      for (int i = 1; i < ENTRIES; i++) begin
         pos_oh[i] = lt_ff[i-1] && !lt_ff[i];
      end
   end

   always_comb begin
      pos      = '0;
      sel_key  = '0;
      sel_mask = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (pos_oh[i] && ((i >> b) & 1) == 1) begin
               pos[b] = 1'b1;
            end
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (pos_oh[i]) begin
            sel_key  = sel_key | key_ff[i];
            sel_mask = sel_mask | mask_ff[i];
         end
      end
   end

   assign merged     = |eq_ff;
   assign any_hit    = |hit_ff;
   assign full       = int'(count_ff) >= ENTRIES;
   assign do_merge   = (req_ff.op == sksi_pkg::OP_INSERT) && !id_bad && !any_hit && merged;
   assign do_insert  = (req_ff.op == sksi_pkg::OP_INSERT) && !id_bad && !any_hit &&
                       !merged && !full;
   assign pos_wide   = PW'(pos);
   assign rank_wide  = PW'(req_ff.rank);
   assign rank_idx   = rank_wide[IDX_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (req_ff.op == sksi_pkg::OP_CLEAR) begin
         count_in = '0;
      end else if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign count_wide = CW'(count_in);

   always_comb begin
      rsp_in               = '0;
      rsp_in.entry_count   = count_wide[4:0];
      case (req_ff.op)
         sksi_pkg::OP_CLEAR: begin
            rsp_in.status = sksi_pkg::ST_CLEARED;
         end
         sksi_pkg::OP_READ: begin
            rsp_in.position = req_ff.rank;
            if (int'(req_ff.rank) < int'(count_ff)) begin
               rsp_in.status        = sksi_pkg::ST_READ_OK;
               rsp_in.entry_key     = key_ff[rank_idx];
               rsp_in.entry_members = 32'(mask_ff[rank_idx]);
            end else begin
               rsp_in.status = sksi_pkg::ST_BAD_RANK;
            end
         end
         sksi_pkg::OP_INSERT: begin
            if (id_bad || any_hit) begin
               rsp_in.status = sksi_pkg::ST_ID_HELD;
            end else if (merged) begin
               rsp_in.status        = sksi_pkg::ST_MERGED;
               rsp_in.position      = pos_wide[3:0];
               rsp_in.entry_key     = sel_key;
               rsp_in.entry_members = 32'(sel_mask | id_bit);
            end else if (full) begin
               rsp_in.status = sksi_pkg::ST_FULL;
            end else begin
               rsp_in.status        = sksi_pkg::ST_NEW_ENTRY;
               rsp_in.position      = pos_wide[3:0];
               rsp_in.entry_key     = req_ff.key_value;
               rsp_in.entry_members = 32'(id_bit);
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.eval) begin
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
         hit_ff <= hit_in;
      end
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end
   end

   // shift cells above the insert point up by one, drop the new entry in place; a merge adds the id to that entry
   always_ff @(posedge clock) begin
      if (cmd.apply && do_insert) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (pos_oh[i]) begin
               key_ff[i]  <= req_ff.key_value;
               mask_ff[i] <= id_bit;
            end else if (i > 0 && !lt_ff[(i > 0) ? i-1 : 0]) begin
               key_ff[i]  <= key_ff[(i > 0) ? i-1 : 0];
               mask_ff[i] <= mask_ff[(i > 0) ? i-1 : 0];
            end
         end
      end else if (cmd.apply && do_merge) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (pos_oh[i]) begin
               mask_ff[i] <= mask_ff[i] | id_bit;
            end
         end
      end
   end

   assign stat.has_result = req_ff.op != sksi_pkg::OP_NONE;
   assign rsp_item        = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ENTRIES)
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.apply |=> $stable(count_ff))
      else $error("entry count moved outside an update");

   a_pos_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $onehot0(pos_oh))
      else $error("insert point not unique");
`endif

endmodule

// ===== src/sksi_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the sorted key set: capture, compare, update, strobe.
// Depends on sksi_pkg for the command and status structs.
module sksi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output sksi_pkg::cmd_type   cmd,
   input  sksi_pkg::stat_type  stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in  = S_IDLE;
            strobe_in = stat.has_result;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy        = state_ff != S_IDLE;
   assign rsp_strobe  = strobe_ff;
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.eval    = state_ff == S_EVAL;
   assign cmd.apply   = state_ff == S_APPLY;

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_EVAL))
      else $error("accepted beat did not enter compare");

   a_eval_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |=> (state_ff == S_APPLY))
      else $error("compare not followed by update");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == S_APPLY))
      else $error("result strobe without update");
`endif

endmodule

// ===== dv/tb_sorted_key_set_insert_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_set_insert_top. A scoreboard keeps its own sorted
// key table, predicts each result beat and checks the beats in order.
// Depends on sksi_pkg and the block's RTL.
module tb_sorted_key_set_insert_top;

   localparam int MAX_ENTRIES  = 16;
   localparam int MAX_ITEMS    = 32;
   localparam int RANDOM_ITEMS = 880;
   localparam int QUIET_TAIL   = 100;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int POOL_DEPTH   = 24;

   class key_set_scoreboard;
      logic signed [31:0] held_keys[MAX_ENTRIES];
      logic [31:0]        held_members[MAX_ENTRIES];
      int                 held_count;
      sksi_pkg::rsp_type  due_q[$];
      int                 errors;

      function new();
         held_count = 0;
         errors     = 0;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      // Work out the result of one accepted request beat and queue it.
      function void note_request(input sksi_pkg::req_type r);
         sksi_pkg::rsp_type e;
         logic [31:0]       bit_mask;
         int                pos;
         bit                id_held;
         e = '0;
         case (r.op)
            sksi_pkg::OP_CLEAR: begin
               held_count = 0;
               e.status   = sksi_pkg::ST_CLEARED;
            end
            sksi_pkg::OP_READ: begin
               e.position = r.rank;
               if (r.rank >= held_count) begin
                  e.status = sksi_pkg::ST_BAD_RANK;
               end else begin
                  e.status        = sksi_pkg::ST_READ_OK;
                  e.entry_key     = held_keys[r.rank];
                  e.entry_members = held_members[r.rank];
               end
            end
            sksi_pkg::OP_INSERT: begin
               bit_mask = 32'd1 << r.item_id;
               id_held  = (r.item_id >= MAX_ITEMS);
               for (int i = 0; i < held_count; i++)
                  if ((held_members[i] & bit_mask) != 0) id_held = 1'b1;
               pos = 0;
               while (pos < held_count && held_keys[pos] < r.key_value) pos++;
               if (id_held) begin
                  e.status = sksi_pkg::ST_ID_HELD;
               end else if (pos < held_count && held_keys[pos] == r.key_value) begin
                  // equal key joins the entry, even with the table full
                  held_members[pos] = held_members[pos] | bit_mask;
                  e.status        = sksi_pkg::ST_MERGED;
                  e.position      = 4'(pos);
                  e.entry_key     = held_keys[pos];
                  e.entry_members = held_members[pos];
               end else if (held_count >= MAX_ENTRIES) begin
                  e.status = sksi_pkg::ST_FULL;
               end else begin
                  for (int i = held_count; i > pos; i--) begin
                     held_keys[i]    = held_keys[i - 1];
                     held_members[i] = held_members[i - 1];
                  end
                  held_keys[pos]    = r.key_value;
                  held_members[pos] = bit_mask;
                  held_count++;
                  e.status        = sksi_pkg::ST_NEW_ENTRY;
                  e.position      = 4'(pos);
                  e.entry_key     = r.key_value;
                  e.entry_members = bit_mask;
               end
            end
            default: return;
         endcase
         e.entry_count = 5'(held_count);
         due_q.push_back(e);
      endfunction

      function void compare_field(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(input sksi_pkg::rsp_type got);
         sksi_pkg::rsp_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            return;
         end
         want = due_q.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("position", 32'(want.position), 32'(got.position));
         compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
         compare_field("entry_key", want.entry_key, got.entry_key);
         compare_field("entry_members", want.entry_members, got.entry_members);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   sksi_pkg::req_type req_item;
   logic              rsp_strobe;
   sksi_pkg::rsp_type rsp_item;

   key_set_scoreboard  table_sb;
   int                 quiet_cycles = 0;
   logic signed [31:0] key_pool[POOL_DEPTH];

   sorted_key_set_insert_top #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .MAX_ITEMS  (MAX_ITEMS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hold the beat until the block takes it; start stays high for the next beat.
   task automatic send_beat(input logic [1:0] op, input logic [4:0] id,
                            input logic signed [31:0] key, input logic [3:0] rank);
      sksi_pkg::req_type r;
      r.op        = op;
      r.item_id   = id;
      r.key_value = key;
      r.rank      = rank;
      req_item <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      table_sb.note_request(r);
   endtask

   task automatic idle_gap(input int cycles);
      start    <= 1'b0;
      req_item <= sksi_pkg::req_type'(43'({$urandom, $urandom}));
      repeat (cycles) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) table_sb.check_result(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int                 n_items;
      int                 pool_size;
      int                 phase_len;
      int                 idle_pct;
      int                 pick;
      logic [1:0]         op;
      logic [4:0]         id;
      logic signed [31:0] key;
      logic [3:0]         rank;

      table_sb = new();
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, each corner case
      send_beat(sksi_pkg::OP_CLEAR, 5'd0, 32'sd0, 4'd0);
      send_beat(sksi_pkg::OP_READ, 5'd0, 32'sd0, 4'd0);           // empty table
      send_beat(sksi_pkg::OP_INSERT, 5'd0, 32'sd0, 4'd0);
      send_beat(sksi_pkg::OP_INSERT, 5'd31, 32'h7FFF_FFFF, 4'd0);
      send_beat(sksi_pkg::OP_INSERT, 5'd1, 32'h8000_0000, 4'd0);
      send_beat(sksi_pkg::OP_INSERT, 5'd2, 32'sd0, 4'hF);          // merge on equal key
      send_beat(sksi_pkg::OP_INSERT, 5'd0, 32'sd5, 4'd0);          // id already held
      send_beat(sksi_pkg::OP_READ, 5'd0, 32'sd0, 4'd1);
      send_beat(sksi_pkg::OP_NONE, 5'h1F, 32'hFFFF_FFFF, 4'hF);    // no result
      send_beat(sksi_pkg::OP_READ, 5'd0, 32'sd0, 4'd3);            // rank past the end
      for (int i = 3; i < 16; i++)
         send_beat(sksi_pkg::OP_INSERT, 5'(i), 32'(i * 65536), 4'd0);
      send_beat(sksi_pkg::OP_INSERT, 5'd16, 32'h0001_8000, 4'd0);  // table full
      send_beat(sksi_pkg::OP_INSERT, 5'd17, 32'h0003_0000, 4'd0);  // merge while full
      send_beat(sksi_pkg::OP_READ, 5'd0, 32'sd0, 4'hF);
      send_beat(sksi_pkg::OP_CLEAR, 5'h1F, 32'hFFFF_FFFF, 4'hF);

      n_items = 0;
      while (n_items < RANDOM_ITEMS) begin
         // small pools of keys make merges, adjacent keys and a full table likely
         pool_size = $urandom_range(2, POOL_DEPTH);
         for (int k = 0; k < pool_size; k++) begin
            case ($urandom_range(0, 5))
               0: key_pool[k] = 32'h8000_0000;
               1: key_pool[k] = 32'h7FFF_FFFF;
               2: key_pool[k] = (k > 0) ? key_pool[k - 1] + 1 : 32'sd0;
               3: key_pool[k] = (k > 0) ? key_pool[k - 1] - 1 : -32'sd1;
               default: key_pool[k] = $signed($urandom);
            endcase
         end
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
         endcase
         if ($urandom_range(0, 9) < 7) begin
            send_beat(sksi_pkg::OP_CLEAR, 5'($urandom), $signed($urandom), 4'($urandom));
            n_items++;
         end
         phase_len = $urandom_range(10, 60);
         for (int j = 0; j < phase_len; j++) begin
            if (n_items < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
               idle_gap($urandom_range(1, 10));
            pick = $urandom_range(0, 99);
            id   = 5'($urandom);
            key  = $signed($urandom);
            rank = 4'($urandom);
            if (pick < 60) begin
               op = sksi_pkg::OP_INSERT;
               if ($urandom_range(0, 9) != 0) key = key_pool[$urandom_range(0, pool_size - 1)];
            end else if (pick < 88) begin
               op = sksi_pkg::OP_READ;
               if (table_sb.held_count > 0 && $urandom_range(0, 1) == 0)
                  rank = 4'($urandom_range(0, table_sb.held_count - 1));
            end else if (pick < 95) begin
               op = sksi_pkg::OP_CLEAR;
            end else begin
               op = sksi_pkg::OP_NONE;
            end
            send_beat(op, id, key, rank);
            if (op != sksi_pkg::OP_NONE) n_items++;
         end
      end

      start <= 1'b0;
      while (table_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sksi_pkg.sv
src/sksi_datapath.sv
src/sksi_ctrl.sv
src/sorted_key_set_insert_top.sv
dv/tb_sorted_key_set_insert_top.sv
